// File: rtl/spz_pkg.sv
// ----------------------------------------------------------------------------
// spz_pkg
// Shared types, constants and the multiply sequence of the sphere point
// projector with depth buffer.
// ----------------------------------------------------------------------------
package spz_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 40;
	localparam int CELL_COUNT     = 4096;
	localparam int LIGHT_GAIN     = 11583;

	localparam logic [7:0] GLYPH_SPACE = 8'd32;

	localparam logic OP_PLOT = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [2:0] REG_RADIUS   = 3'd0;
	localparam logic [2:0] REG_COS      = 3'd1;
	localparam logic [2:0] REG_SIN      = 3'd2;
	localparam logic [2:0] REG_DISTANCE = 3'd3;
	localparam logic [2:0] REG_FOV      = 3'd4;
	localparam logic [2:0] REG_STRETCH  = 3'd5;

	localparam logic [4:0] STEP_LAST = 5'd25;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] sin_theta;
		logic signed [15:0] cos_theta;
		logic signed [15:0] sin_phi;
		logic signed [15:0] cos_phi;
		logic [11:0]        read_cell;
	} spz_in_t;

	typedef struct packed {
		logic [11:0] cell_res;
		logic [7:0]  glyph;
		logic        plotted;
	} spz_out_t;

	typedef struct packed {
		logic [15:0]        radius;
		logic signed [15:0] cos_angle;
		logic signed [15:0] sin_angle;
		logic [15:0]        z_offset;
		logic [15:0]        field_of_view;
		logic [15:0]        horizontal_stretch;
	} spz_cfg_t;

	typedef struct packed {
		logic    valid;
		logic    is_read;
		spz_in_t item;
	} spz_job_t;

	typedef enum logic [4:0] {
		A_R, A_P, A_CA, A_SA, A_SS, A_CS, A_CC, A_SX, A_SY, A_SZ,
		A_ST, A_Q, A_RX, A_RY, A_UX, A_TX, A_UY
	} a_sel_t;

	typedef enum logic [3:0] {
		B_ST, B_CP, B_SP, B_CT, B_CA, B_SA, B_CC_SSS, B_CS_CSS, B_SS_CCS,
		B_CS, B_CC, B_ZINV, B_FOV, B_STRETCH, B_LIGHT
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_LOAD, ACC_ADD, ACC_SUB, ACC_NEG
	} acc_op_t;

	typedef enum logic [4:0] {
		DST_NONE, DST_P, DST_SX, DST_SY, DST_SZ, DST_CC, DST_CS, DST_SS,
		DST_SSS, DST_CSS, DST_CCS, DST_RZ, DST_RX, DST_RY, DST_Q, DST_SHADE,
		DST_UX, DST_TX, DST_XO, DST_UY, DST_YO
	} dst_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		dst_t    dst;
	} micro_t;

	typedef enum logic [2:0] {
		BS_CLEAR, BS_IDLE, BS_MUL, BS_ACC, BS_POS, BS_CHECK, BS_RESULT
	} back_state_t;

	function automatic micro_t prog(input logic [4:0] step);
		micro_t m;
		m = '{A_R, B_ST, ACC_LOAD, DST_NONE};
		unique case (step)
			5'd0:  m = '{A_R,  B_ST,      ACC_LOAD, DST_P};
			5'd1:  m = '{A_P,  B_CP,      ACC_LOAD, DST_SX};
			5'd2:  m = '{A_P,  B_SP,      ACC_LOAD, DST_SY};
			5'd3:  m = '{A_R,  B_CT,      ACC_LOAD, DST_SZ};
			5'd4:  m = '{A_CA, B_CA,      ACC_LOAD, DST_CC};
			5'd5:  m = '{A_CA, B_SA,      ACC_LOAD, DST_CS};
			5'd6:  m = '{A_SA, B_SA,      ACC_LOAD, DST_SS};
			5'd7:  m = '{A_SS, B_SA,      ACC_LOAD, DST_SSS};
			5'd8:  m = '{A_CS, B_SA,      ACC_LOAD, DST_CSS};
			5'd9:  m = '{A_CC, B_SA,      ACC_LOAD, DST_CCS};
			5'd10: m = '{A_SX, B_CS_CSS,  ACC_LOAD, DST_NONE};
			5'd11: m = '{A_SY, B_SS_CCS,  ACC_ADD,  DST_NONE};
			5'd12: m = '{A_SZ, B_CC,      ACC_ADD,  DST_RZ};
			5'd13: m = '{A_SX, B_CC_SSS,  ACC_LOAD, DST_NONE};
			5'd14: m = '{A_SY, B_CS_CSS,  ACC_ADD,  DST_NONE};
			5'd15: m = '{A_SZ, B_CS,      ACC_SUB,  DST_RX};
			5'd16: m = '{A_SX, B_CS,      ACC_NEG,  DST_NONE};
			5'd17: m = '{A_SY, B_CC,      ACC_ADD,  DST_NONE};
			5'd18: m = '{A_SZ, B_SA,      ACC_ADD,  DST_RY};
			5'd19: m = '{A_ST, B_SP,      ACC_LOAD, DST_Q};
			5'd20: m = '{A_Q,  B_LIGHT,   ACC_LOAD, DST_SHADE};
			5'd21: m = '{A_RX, B_ZINV,    ACC_LOAD, DST_UX};
			5'd22: m = '{A_UX, B_FOV,     ACC_LOAD, DST_TX};
			5'd23: m = '{A_TX, B_STRETCH, ACC_LOAD, DST_XO};
			5'd24: m = '{A_RY, B_ZINV,    ACC_LOAD, DST_UY};
			5'd25: m = '{A_UY, B_FOV,     ACC_LOAD, DST_YO};
			default: m = '{A_R, B_ST, ACC_LOAD, DST_NONE};
		endcase
		return m;
	endfunction

	function automatic logic [7:0] shade_char(input logic [2:0] shade);
		logic [7:0] c;
		unique case (shade)
			3'd0: c = 8'd46;
			3'd1: c = 8'd44;
			3'd2: c = 8'd58;
			3'd3: c = 8'd59;
			3'd4: c = 8'd61;
			3'd5: c = 8'd35;
			3'd6: c = 8'd36;
			3'd7: c = 8'd64;
			default: c = GLYPH_SPACE;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/sphere_point_project_zbuffer.sv
// ----------------------------------------------------------------------------
// sphere_point_project_zbuffer
// Perspective splat of sphere surface points into a character screen with a
// nearest-depth buffer and shade store.
// ----------------------------------------------------------------------------
// A plot transaction runs its 26 products one after another through a single
// shared multiplier, each product taking a multiply state and an accumulate
// state, and the reciprocal of rz runs beside the later products; the first
// product that needs the reciprocal waits for it. A read transaction goes
// through the registered read of the depth and shade memory and its clearing write.
// A two-entry queue takes new transactions while the back end works, and a
// result register holds the finished result until it is taken. After reset a
// clearing pass over all 4096 cells empties the memory; no transaction is taken
// during it, while register writes are taken as always.
module sphere_point_project_zbuffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  spz_pkg::spz_in_t  item,
	output logic              res_valid,
	input  logic              res_ready,
	output spz_pkg::spz_out_t res,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data
);

	spz_pkg::spz_cfg_t cfg_q;
	spz_pkg::spz_job_t job;
	logic              job_ready;
	logic              clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius             <= 16'd256;
			cfg_q.cos_angle          <= 16'sd16384;
			cfg_q.sin_angle          <= 16'sd0;
			cfg_q.z_offset           <= 16'd1280;
			cfg_q.field_of_view      <= 16'd5120;
			cfg_q.horizontal_stretch <= 16'd512;
		end else if (wr_en) begin
			case (wr_index)
				spz_pkg::REG_RADIUS:   cfg_q.radius             <= wr_data;
				spz_pkg::REG_COS:      cfg_q.cos_angle          <= $signed(wr_data);
				spz_pkg::REG_SIN:      cfg_q.sin_angle          <= $signed(wr_data);
				spz_pkg::REG_DISTANCE: cfg_q.z_offset           <= wr_data;
				spz_pkg::REG_FOV:      cfg_q.field_of_view      <= wr_data;
				spz_pkg::REG_STRETCH:  cfg_q.horizontal_stretch <= wr_data;
				default: ;
			endcase
		end
	end

	spz_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.block      (clearing),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.job        (job),
		.job_ready  (job_ready)
	);

	spz_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (job),
		.job_ready (job_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.clearing  (clearing)
	);

	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !item_ready)
		else $error("transaction taken during clearing pass");

	a_plot_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.plotted |->
			(res.glyph != spz_pkg::GLYPH_SPACE)
			&& (int'(res.cell_res) < spz_pkg::SCREEN_COLUMNS * spz_pkg::SCREEN_ROWS))
		else $error("plotted result off screen or blank");

	a_no_job_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !job_ready && !res_valid)
		else $error("back end active during clearing pass");

endmodule

// File: rtl/spz_div.sv
// ----------------------------------------------------------------------------
// spz_div
// Restoring divider forming the saturated 24-bit reciprocal 2^24 / divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spz_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [23:0] zinv
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [24:0] rem_q;
	logic [24:0] quo_q;
	logic [23:0] d_q;
	logic [24:0] trial;
	logic        ge;

	assign trial = {rem_q[23:0], (cnt_q == 5'd24)};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd24;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, d_q}) : trial;
			quo_q <= {quo_q[23:0], ge};
		end
	end

	assign done = done_q;
	assign zinv = quo_q[24] ? 24'hFFFFFF : quo_q[23:0];

endmodule

// File: rtl/spz_front.sv
// ----------------------------------------------------------------------------
// spz_front
// Input side: accepts transactions, tags them as plot or read, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module spz_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              block,
	input  logic              item_valid,
	output logic              item_ready,
	input  spz_pkg::spz_in_t  item,
	output spz_pkg::spz_job_t job,
	input  logic              job_ready
);

	spz_pkg::spz_in_t buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign item_ready = (cnt_q != 2'd2) && !block;
	assign push       = item_valid && item_ready;
	assign pop        = job.valid && job_ready;

	assign job.valid   = cnt_q != 2'd0;
	assign job.item    = buf_q[rd_ptr_q];
	assign job.is_read = buf_q[rd_ptr_q].operation == spz_pkg::OP_READ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= item;
	end

endmodule

// File: rtl/spz_back.sv
// ----------------------------------------------------------------------------
// spz_back
// Execution side: shared multiply-accumulate sequencer, reciprocal divider,
// depth and shade memory with its clearing pass, and the result register.
// ----------------------------------------------------------------------------
module spz_back (
	input  logic              clk,
	input  logic              arst_n,
	input  spz_pkg::spz_cfg_t cfg,
	input  spz_pkg::spz_job_t job,
	output logic              job_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output spz_pkg::spz_out_t res,
	output logic              clearing
);

	localparam logic signed [59:0] U_LIM  = 60'sd4294967296;
	localparam logic signed [59:0] T_LIM  = 60'sd16777216;
	localparam logic signed [59:0] XY_LIM = 60'sd131072;

	spz_pkg::back_state_t state_q, state_d;
	spz_pkg::micro_t      mc;

	logic [4:0]  step_q;
	logic [11:0] clr_addr_q;
	logic        res_valid_q;

	spz_pkg::spz_in_t  item_q;
	spz_pkg::spz_out_t pend_q;
	spz_pkg::spz_out_t res_q;
	logic [11:0]       cell_q;

	logic signed [59:0] prod_q, acc_q, acc_nx;
	logic signed [32:0] p_q;
	logic signed [19:0] sx_q, sy_q, sz_q;
	logic signed [17:0] cc_q, cs_q, ss_q;
	logic signed [18:0] sss_q, css_q, ccs_q;
	logic signed [24:0] rx_q, ry_q, rz_nx;
	logic [17:0]        q_q;
	logic signed [18:0] qd;
	logic [2:0]         shade_q;
	logic signed [33:0] ux_q, uy_q;
	logic signed [25:0] tx_q;
	logic signed [18:0] xo_q, yo_q;

	logic signed [33:0] a_op;
	logic signed [25:0] b_op;
	logic signed [25:0] cc_sss, cs_css, ss_ccs;

	logic signed [20:0] col_s, row_s;
	logic signed [12:0] col_v, row_v;
	logic [15:0]        cell_full;
	logic               pos_ok;

	logic        div_start, div_done;
	logic [23:0] zinv;

	logic [27:0] mem [spz_pkg::CELL_COUNT];
	logic [27:0] rd_q;
	logic        mem_we, mem_re;
	logic [11:0] mem_wa, mem_ra;
	logic [27:0] mem_wd;
	logic        mul_go;
	logic        win;
	logic [3:0]  stored_shade;
	logic [7:0]  read_glyph;

	function automatic logic signed [59:0] clamp_sym(
		input logic signed [59:0] v,
		input logic signed [59:0] lim
	);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	spz_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (rz_nx[23:0]),
		.done    (div_done),
		.zinv    (zinv)
	);

	assign mc = spz_pkg::prog(step_q);

	assign cc_sss = 26'(cc_q) - 26'(sss_q);
	assign cs_css = 26'(cs_q) + 26'(css_q);
	assign ss_ccs = 26'(ss_q) - 26'(ccs_q);

	always_comb begin
		unique case (mc.a_sel)
			spz_pkg::A_R:  a_op = $signed({18'd0, cfg.radius});
			spz_pkg::A_P:  a_op = 34'(p_q);
			spz_pkg::A_CA: a_op = 34'(cfg.cos_angle);
			spz_pkg::A_SA: a_op = 34'(cfg.sin_angle);
			spz_pkg::A_SS: a_op = 34'(ss_q);
			spz_pkg::A_CS: a_op = 34'(cs_q);
			spz_pkg::A_CC: a_op = 34'(cc_q);
			spz_pkg::A_SX: a_op = 34'(sx_q);
			spz_pkg::A_SY: a_op = 34'(sy_q);
			spz_pkg::A_SZ: a_op = 34'(sz_q);
			spz_pkg::A_ST: a_op = 34'(item_q.sin_theta);
			spz_pkg::A_Q:  a_op = $signed({16'd0, q_q});
			spz_pkg::A_RX: a_op = 34'(rx_q);
			spz_pkg::A_RY: a_op = 34'(ry_q);
			spz_pkg::A_UX: a_op = ux_q;
			spz_pkg::A_TX: a_op = 34'(tx_q);
			spz_pkg::A_UY: a_op = uy_q;
			default:       a_op = '0;
		endcase
		unique case (mc.b_sel)
			spz_pkg::B_ST:      b_op = 26'(item_q.sin_theta);
			spz_pkg::B_CP:      b_op = 26'(item_q.cos_phi);
			spz_pkg::B_SP:      b_op = 26'(item_q.sin_phi);
			spz_pkg::B_CT:      b_op = 26'(item_q.cos_theta);
			spz_pkg::B_CA:      b_op = 26'(cfg.cos_angle);
			spz_pkg::B_SA:      b_op = 26'(cfg.sin_angle);
			spz_pkg::B_CC_SSS:  b_op = cc_sss;
			spz_pkg::B_CS_CSS:  b_op = cs_css;
			spz_pkg::B_SS_CCS:  b_op = ss_ccs;
			spz_pkg::B_CS:      b_op = 26'(cs_q);
			spz_pkg::B_CC:      b_op = 26'(cc_q);
			spz_pkg::B_ZINV:    b_op = $signed({2'd0, zinv});
			spz_pkg::B_FOV:     b_op = $signed({10'd0, cfg.field_of_view});
			spz_pkg::B_STRETCH: b_op = $signed({10'd0, cfg.horizontal_stretch});
			spz_pkg::B_LIGHT:   b_op = 26'(spz_pkg::LIGHT_GAIN);
			default:            b_op = '0;
		endcase
		unique case (mc.acc_op)
			spz_pkg::ACC_LOAD: acc_nx = prod_q;
			spz_pkg::ACC_ADD:  acc_nx = acc_q + prod_q;
			spz_pkg::ACC_SUB:  acc_nx = acc_q - prod_q;
			spz_pkg::ACC_NEG:  acc_nx = -prod_q;
			default:           acc_nx = prod_q;
		endcase
	end

	assign rz_nx = 25'(acc_nx >>> 14) + $signed({9'd0, cfg.z_offset});
	assign qd    = 19'(item_q.cos_theta) - 19'(acc_nx >>> 14);

	assign col_s     = 21'(spz_pkg::SCREEN_COLUMNS / 2 * 256) + 21'(xo_q);
	assign row_s     = 21'(spz_pkg::SCREEN_ROWS / 2 * 256) - 21'(yo_q);
	assign col_v     = 13'(col_s >>> 8);
	assign row_v     = 13'(row_s >>> 8);
	assign cell_full = 16'(row_v[6:0]) * 16'(spz_pkg::SCREEN_COLUMNS) + 16'(col_v[7:0]);
	assign pos_ok    = (col_v >= 13'sd0) && (col_v < 13'(spz_pkg::SCREEN_COLUMNS))
		&& (row_v >= 13'sd0) && (row_v < 13'(spz_pkg::SCREEN_ROWS))
		&& (cell_full < 16'(spz_pkg::CELL_COUNT));

	assign win          = zinv > rd_q[27:4];
	assign stored_shade = rd_q[3:0];
	assign read_glyph   = (stored_shade >= 4'd1 && stored_shade <= 4'd8)
		? spz_pkg::shade_char(3'(stored_shade - 4'd1)) : spz_pkg::GLYPH_SPACE;

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = clr_addr_q;
		mem_wd    = '0;
		mem_re    = 1'b0;
		mem_ra    = job.item.read_cell;
		div_start = 1'b0;
		mul_go    = 1'b0;
		unique case (state_q)
			spz_pkg::BS_CLEAR: begin
				mem_we = 1'b1;
				if (clr_addr_q == '1) state_d = spz_pkg::BS_IDLE;
			end
			spz_pkg::BS_IDLE: begin
				job_ready = 1'b1;
				if (job.valid) begin
					if (job.is_read) begin
						mem_re  = 1'b1;
						state_d = spz_pkg::BS_CHECK;
					end else begin
						state_d = spz_pkg::BS_MUL;
					end
				end
			end
			spz_pkg::BS_MUL: begin
				if (!(mc.b_sel == spz_pkg::B_ZINV && !div_done)) begin
					mul_go  = 1'b1;
					state_d = spz_pkg::BS_ACC;
				end
			end
			spz_pkg::BS_ACC: begin
				if (mc.dst == spz_pkg::DST_RZ && rz_nx <= 25'sd0) begin
					state_d = spz_pkg::BS_RESULT;
				end else begin
					if (mc.dst == spz_pkg::DST_RZ) div_start = 1'b1;
					if (step_q == spz_pkg::STEP_LAST) state_d = spz_pkg::BS_POS;
					else state_d = spz_pkg::BS_MUL;
				end
			end
			spz_pkg::BS_POS: begin
				if (pos_ok) begin
					mem_re  = 1'b1;
					mem_ra  = cell_full[11:0];
					state_d = spz_pkg::BS_CHECK;
				end else begin
					state_d = spz_pkg::BS_RESULT;
				end
			end
			spz_pkg::BS_CHECK: begin
				mem_wa = cell_q;
				if (item_q.operation == spz_pkg::OP_READ) begin
					mem_we = 1'b1;
				end else if (win) begin
					mem_we = 1'b1;
					mem_wd = {zinv, {1'b0, shade_q} + 4'd1};
				end
				state_d = spz_pkg::BS_RESULT;
			end
			spz_pkg::BS_RESULT: begin
				if (!res_valid_q || res_ready) state_d = spz_pkg::BS_IDLE;
			end
			default: state_d = spz_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spz_pkg::BS_CLEAR;
			step_q      <= '0;
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spz_pkg::BS_CLEAR) clr_addr_q <= clr_addr_q + 12'd1;
			if (state_q == spz_pkg::BS_IDLE) step_q <= '0;
			else if (state_q == spz_pkg::BS_ACC && state_d == spz_pkg::BS_MUL)
				step_q <= step_q + 5'd1;
			if (state_q == spz_pkg::BS_RESULT && state_d == spz_pkg::BS_IDLE)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spz_pkg::BS_IDLE && job.valid) begin
			item_q <= job.item;
			cell_q <= job.item.read_cell;
		end
		if (mul_go) prod_q <= a_op * b_op;
		if (state_q == spz_pkg::BS_ACC) begin
			acc_q <= acc_nx;
			unique case (mc.dst)
				spz_pkg::DST_NONE:  ;
				spz_pkg::DST_P:     p_q   <= acc_nx[32:0];
				spz_pkg::DST_SX:    sx_q  <= 20'(acc_nx >>> 28);
				spz_pkg::DST_SY:    sy_q  <= 20'(acc_nx >>> 28);
				spz_pkg::DST_SZ:    sz_q  <= 20'(acc_nx >>> 14);
				spz_pkg::DST_CC:    cc_q  <= 18'(acc_nx >>> 14);
				spz_pkg::DST_CS:    cs_q  <= 18'(acc_nx >>> 14);
				spz_pkg::DST_SS:    ss_q  <= 18'(acc_nx >>> 14);
				spz_pkg::DST_SSS:   sss_q <= 19'(acc_nx >>> 14);
				spz_pkg::DST_CSS:   css_q <= 19'(acc_nx >>> 14);
				spz_pkg::DST_CCS:   ccs_q <= 19'(acc_nx >>> 14);
				spz_pkg::DST_RZ: begin
					if (rz_nx <= 25'sd0) pend_q <= '{12'd0, spz_pkg::GLYPH_SPACE, 1'b0};
				end
				spz_pkg::DST_RX:    rx_q  <= 25'(acc_nx >>> 14);
				spz_pkg::DST_RY:    ry_q  <= 25'(acc_nx >>> 14);
				spz_pkg::DST_Q:     q_q   <= qd[18] ? 18'(-qd) : 18'(qd);
				spz_pkg::DST_SHADE: shade_q <= (|acc_nx[59:28]) ? 3'd7 : acc_nx[27:25];
				spz_pkg::DST_UX:    ux_q  <= 34'(clamp_sym(acc_nx >>> 16, U_LIM));
				spz_pkg::DST_TX:    tx_q  <= 26'(clamp_sym(acc_nx >>> 8, T_LIM));
				spz_pkg::DST_XO:    xo_q  <= 19'(clamp_sym(acc_nx >>> 8, XY_LIM));
				spz_pkg::DST_UY:    uy_q  <= 34'(clamp_sym(acc_nx >>> 16, U_LIM));
				spz_pkg::DST_YO:    yo_q  <= 19'(clamp_sym(acc_nx >>> 8, XY_LIM));
				default: ;
			endcase
		end
		if (state_q == spz_pkg::BS_POS) begin
			cell_q <= cell_full[11:0];
			if (!pos_ok) pend_q <= '{12'd0, spz_pkg::GLYPH_SPACE, 1'b0};
		end
		if (state_q == spz_pkg::BS_CHECK) begin
			if (item_q.operation == spz_pkg::OP_READ)
				pend_q <= '{cell_q, read_glyph, 1'b0};
			else if (win)
				pend_q <= '{cell_q, spz_pkg::shade_char(shade_q), 1'b1};
			else
				pend_q <= '{cell_q, spz_pkg::GLYPH_SPACE, 1'b0};
		end
		if (state_q == spz_pkg::BS_RESULT && state_d == spz_pkg::BS_IDLE) res_q <= pend_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign clearing  = state_q == spz_pkg::BS_CLEAR;

endmodule
